>>> hw/rtl/mlfq_pkg.sv
`default_nettype none

package mlfq_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int NUM_LEVELS = 5;
    localparam int NUM_QREGS  = 5;

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int STEP_W  = $clog2(NUM_LEVELS + 1);
    localparam int LEVEL_W = 3;
    localparam int PID_W   = 8;
    localparam int QUANT_W = 32;
    localparam int TIME_W  = 64;
    localparam int DATA_W  = 64;
    localparam int ADDR_W  = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(NUM_LEVELS - 1);
    localparam logic [LEVEL_W-1:0] TOP_QREG   = LEVEL_W'(NUM_QREGS - 1);

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_CHARGE = 2'd2;
    localparam logic [1:0] REQ_CHECK  = 2'd3;

    localparam logic [1:0] RES_OK        = 2'd0;
    localparam logic [1:0] RES_FULL      = 2'd1;
    localparam logic [1:0] RES_NOT_FOUND = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_QUANTUM0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_QUANTUM1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_QUANTUM2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_QUANTUM3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_QUANTUM4 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SHELL    = 3'd6;

    localparam logic [QUANT_W-1:0] QUANTUM0_RST = 32'd100000;
    localparam logic [QUANT_W-1:0] QUANTUM1_RST = 32'd200000;
    localparam logic [QUANT_W-1:0] QUANTUM2_RST = 32'd300000;
    localparam logic [QUANT_W-1:0] QUANTUM3_RST = 32'd400000;
    localparam logic [QUANT_W-1:0] QUANTUM4_RST = 32'd500000;
    localparam logic [TIME_W-1:0]  PERIOD_RST   = 64'd10000000;
    localparam logic [PID_W-1:0]   SHELL_RST    = 8'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHARGE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic charge;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic charge_end;
    } sts_t;

    typedef struct packed {
        logic [NUM_QREGS-1:0][QUANT_W-1:0] quantum;
        logic [TIME_W-1:0]                 reset_period;
        logic [PID_W-1:0]                  shell_pid;
    } cfg_t;

    function automatic logic [QUANT_W-1:0] level_quantum(
        input logic [NUM_QREGS-1:0][QUANT_W-1:0] q,
        input logic [LEVEL_W-1:0]                lvl
    );
        logic [LEVEL_W-1:0] l;
        l = lvl;
        if (l > LAST_LEVEL)
        begin
            l = LAST_LEVEL;
        end
        if (l > TOP_QREG)
        begin
            l = TOP_QREG;
        end
        return q[l];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mlfq_regs.sv
`default_nettype none

module mlfq_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mlfq_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [mlfq_pkg::DATA_W-1:0]       pwdata,
    output logic      [mlfq_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready,
    output mlfq_pkg::cfg_t                         cfg
);

    logic [mlfq_pkg::NUM_QREGS-1:0][mlfq_pkg::QUANT_W-1:0] quantum_reg;
    logic [mlfq_pkg::TIME_W-1:0]                           period_reg;
    logic [mlfq_pkg::PID_W-1:0]                            shell_reg;
    logic [mlfq_pkg::REG_IDX_W-1:0]                        reg_idx;
    logic                                                  wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[mlfq_pkg::ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg[0] <= mlfq_pkg::QUANTUM0_RST;
            quantum_reg[1] <= mlfq_pkg::QUANTUM1_RST;
            quantum_reg[2] <= mlfq_pkg::QUANTUM2_RST;
            quantum_reg[3] <= mlfq_pkg::QUANTUM3_RST;
            quantum_reg[4] <= mlfq_pkg::QUANTUM4_RST;
            period_reg     <= mlfq_pkg::PERIOD_RST;
            shell_reg      <= mlfq_pkg::SHELL_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                mlfq_pkg::REG_QUANTUM0: quantum_reg[0] <= pwdata[31:0];
                mlfq_pkg::REG_QUANTUM1: quantum_reg[1] <= pwdata[31:0];
                mlfq_pkg::REG_QUANTUM2: quantum_reg[2] <= pwdata[31:0];
                mlfq_pkg::REG_QUANTUM3: quantum_reg[3] <= pwdata[31:0];
                mlfq_pkg::REG_QUANTUM4: quantum_reg[4] <= pwdata[31:0];
                mlfq_pkg::REG_PERIOD:   period_reg     <= pwdata;
                mlfq_pkg::REG_SHELL:    shell_reg      <= pwdata[7:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            mlfq_pkg::REG_QUANTUM0: prdata = {32'd0, quantum_reg[0]};
            mlfq_pkg::REG_QUANTUM1: prdata = {32'd0, quantum_reg[1]};
            mlfq_pkg::REG_QUANTUM2: prdata = {32'd0, quantum_reg[2]};
            mlfq_pkg::REG_QUANTUM3: prdata = {32'd0, quantum_reg[3]};
            mlfq_pkg::REG_QUANTUM4: prdata = {32'd0, quantum_reg[4]};
            mlfq_pkg::REG_PERIOD:   prdata = period_reg;
            mlfq_pkg::REG_SHELL:    prdata = {56'd0, shell_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.quantum      = quantum_reg;
    assign cfg.reset_period = period_reg;
    assign cfg.shell_pid    = shell_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mlfq_ctrl.sv
`default_nettype none

module mlfq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  mlfq_pkg::sts_t     sts,
    output logic               busy,
    output mlfq_pkg::cmd_t     cmd
);

    mlfq_pkg::state_t state_reg;
    mlfq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlfq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlfq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mlfq_pkg::ST_SCAN;
                end
            end
            mlfq_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = mlfq_pkg::ST_CHARGE;
                end
            end
            mlfq_pkg::ST_CHARGE:
            begin
                if (sts.charge_end)
                begin
                    state_next = mlfq_pkg::ST_FINISH;
                end
            end
            mlfq_pkg::ST_FINISH:
            begin
                state_next = mlfq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mlfq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy       = 1'b1;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.charge = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            mlfq_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            mlfq_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            mlfq_pkg::ST_CHARGE:
            begin
                cmd.charge = !sts.charge_end;
            end
            mlfq_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_busy_ends_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(cmd.finish))
        else $error("busy dropped without a finish cycle");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/mlfq_dp.sv
`default_nettype none

module mlfq_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  mlfq_pkg::cmd_t                          cmd,
    input  mlfq_pkg::cfg_t                          cfg,
    input  wire logic [1:0]                         req_type,
    input  wire logic [mlfq_pkg::PID_W-1:0]         target_pid,
    input  wire logic [mlfq_pkg::QUANT_W-1:0]       run_amount,
    input  wire logic [mlfq_pkg::TIME_W-1:0]        time_now,
    input  wire logic                               input_pending,
    output mlfq_pkg::sts_t                          sts,
    output logic                                    done,
    output logic [1:0]                              result_code,
    output logic [mlfq_pkg::PID_W-1:0]              given_pid,
    output logic [mlfq_pkg::LEVEL_W-1:0]            new_level,
    output logic [mlfq_pkg::QUANT_W-1:0]            quantum_left
);

    logic [mlfq_pkg::PID_W-1:0]   owner_reg   [mlfq_pkg::NUM_SLOTS];
    logic [mlfq_pkg::LEVEL_W-1:0] level_reg   [mlfq_pkg::NUM_SLOTS];
    logic [mlfq_pkg::QUANT_W-1:0] slot_q_reg  [mlfq_pkg::NUM_SLOTS];
    logic [mlfq_pkg::NUM_SLOTS-1:0] used_reg;

    logic [1:0]                   req_reg;
    logic [mlfq_pkg::PID_W-1:0]   pid_reg;
    logic                         pending_reg;
    logic                         sweep_reg;
    logic                         found_reg;
    logic [mlfq_pkg::SLOT_W-1:0]  idx_reg;
    logic [mlfq_pkg::SLOT_W-1:0]  idx_next;
    logic [mlfq_pkg::SLOT_W-1:0]  sel_reg;
    logic [mlfq_pkg::STEP_W-1:0]  step_reg;
    logic                         stop_reg;
    logic [mlfq_pkg::PID_W-1:0]   pid_counter_reg;
    logic [mlfq_pkg::PID_W-1:0]   pid_counter_next;
    logic [mlfq_pkg::TIME_W-1:0]  last_reset_reg;

    logic [mlfq_pkg::QUANT_W-1:0] rem_reg;
    logic [mlfq_pkg::QUANT_W-1:0] rem_next;
    logic [mlfq_pkg::LEVEL_W-1:0] lvl_reg;
    logic [mlfq_pkg::LEVEL_W-1:0] lvl_next;
    logic [mlfq_pkg::QUANT_W-1:0] q_reg;
    logic [mlfq_pkg::QUANT_W-1:0] q_next;

    logic                         done_reg;
    logic [1:0]                   code_reg;
    logic [1:0]                   code_next;
    logic [mlfq_pkg::PID_W-1:0]   given_reg;
    logic [mlfq_pkg::LEVEL_W-1:0] new_level_reg;
    logic [mlfq_pkg::QUANT_W-1:0] quantum_left_reg;

    logic [mlfq_pkg::PID_W-1:0]   match_pid;
    logic                         hit;
    logic                         claim;
    logic                         release_hit;
    logic                         pick;
    logic                         shell_top;
    logic                         sweep_top;
    logic                         to_top;
    logic                         charge_active;
    logic                         elapsed;
    logic [mlfq_pkg::TIME_W-1:0]  time_diff;

    assign match_pid   = (req_reg == mlfq_pkg::REQ_CHECK) ? cfg.shell_pid : pid_reg;
    assign hit         = used_reg[idx_reg] && (owner_reg[idx_reg] == match_pid);
    assign claim       = cmd.scan && (req_reg == mlfq_pkg::REQ_ALLOC)
                         && !used_reg[idx_reg] && !found_reg;
    assign release_hit = cmd.scan && (req_reg == mlfq_pkg::REQ_FREE) && hit;
    assign pick        = cmd.scan && (req_reg == mlfq_pkg::REQ_CHARGE) && hit && !found_reg;
    assign shell_top   = cmd.scan && (req_reg == mlfq_pkg::REQ_CHECK) && pending_reg
                         && hit && !found_reg;
    assign sweep_top   = cmd.scan && (req_reg == mlfq_pkg::REQ_CHECK) && sweep_reg
                         && used_reg[idx_reg];
    assign to_top      = claim || shell_top || sweep_top;

    assign time_diff = time_now - last_reset_reg;
    assign elapsed   = time_diff >= cfg.reset_period;

    assign charge_active = (req_reg == mlfq_pkg::REQ_CHARGE) && found_reg;

    assign sts.scan_last  = idx_reg == mlfq_pkg::SLOT_W'(mlfq_pkg::NUM_SLOTS - 1);
    assign sts.charge_end = !charge_active || (rem_reg == '0)
                            || (step_reg == mlfq_pkg::STEP_W'(mlfq_pkg::NUM_LEVELS))
                            || stop_reg;

    assign idx_next         = sts.scan_last ? idx_reg : idx_reg + 1'b1;
    assign pid_counter_next = pid_counter_reg + 1'b1;

    // One demotion step: use up the current quantum or take the runtime from it.
    always_comb
    begin
        if (rem_reg >= q_reg)
        begin
            rem_next = rem_reg - q_reg;
            lvl_next = (lvl_reg < mlfq_pkg::LAST_LEVEL) ? lvl_reg + 1'b1 : lvl_reg;
            q_next   = mlfq_pkg::level_quantum(cfg.quantum, lvl_next);
        end
        else
        begin
            rem_next = '0;
            lvl_next = lvl_reg;
            q_next   = q_reg - rem_reg;
        end
    end

    always_comb
    begin
        case (req_reg)
            mlfq_pkg::REQ_ALLOC:
                code_next = found_reg ? mlfq_pkg::RES_OK : mlfq_pkg::RES_FULL;
            mlfq_pkg::REQ_FREE:
                code_next = found_reg ? mlfq_pkg::RES_OK : mlfq_pkg::RES_NOT_FOUND;
            mlfq_pkg::REQ_CHARGE:
                code_next = found_reg ? mlfq_pkg::RES_OK : mlfq_pkg::RES_NOT_FOUND;
            default:
                code_next = mlfq_pkg::RES_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg         <= mlfq_pkg::REQ_ALLOC;
            pending_reg     <= 1'b0;
            sweep_reg       <= 1'b0;
            found_reg       <= 1'b0;
            idx_reg         <= '0;
            step_reg        <= '0;
            stop_reg        <= 1'b0;
            pid_counter_reg <= '0;
            last_reset_reg  <= '0;
            used_reg        <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                req_reg     <= req_type;
                pending_reg <= input_pending;
                sweep_reg   <= (req_type == mlfq_pkg::REQ_CHECK) && elapsed;
                found_reg   <= 1'b0;
                idx_reg     <= '0;
                step_reg    <= '0;
                stop_reg    <= 1'b0;
                if ((req_type == mlfq_pkg::REQ_CHECK) && elapsed)
                begin
                    last_reset_reg <= time_now;
                end
            end
            if (cmd.scan)
            begin
                idx_reg <= idx_next;
            end
            if (claim || release_hit || pick || shell_top)
            begin
                found_reg <= 1'b1;
            end
            if (claim)
            begin
                used_reg[idx_reg] <= 1'b1;
                pid_counter_reg   <= pid_counter_next;
            end
            if (release_hit)
            begin
                used_reg[idx_reg] <= 1'b0;
            end
            if (cmd.charge)
            begin
                step_reg <= step_reg + 1'b1;
                stop_reg <= lvl_next == mlfq_pkg::LAST_LEVEL;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pid_reg <= target_pid;
            rem_reg <= run_amount;
        end
        if (claim)
        begin
            owner_reg[idx_reg] <= pid_counter_next;
        end
        if (to_top)
        begin
            level_reg[idx_reg]  <= '0;
            slot_q_reg[idx_reg] <= cfg.quantum[0];
        end
        if (pick)
        begin
            sel_reg <= idx_reg;
            lvl_reg <= level_reg[idx_reg];
            q_reg   <= slot_q_reg[idx_reg];
        end
        if (cmd.charge)
        begin
            rem_reg <= rem_next;
            lvl_reg <= lvl_next;
            q_reg   <= q_next;
        end
        if (cmd.finish)
        begin
            if (charge_active)
            begin
                level_reg[sel_reg]  <= lvl_reg;
                slot_q_reg[sel_reg] <= q_reg;
            end
            code_reg         <= code_next;
            given_reg        <= ((req_reg == mlfq_pkg::REQ_ALLOC) && found_reg)
                                ? pid_counter_reg : '0;
            new_level_reg    <= charge_active ? lvl_reg : '0;
            quantum_left_reg <= charge_active ? q_reg : '0;
        end
    end

    assign done         = done_reg;
    assign result_code  = code_reg;
    assign given_pid    = given_reg;
    assign new_level    = new_level_reg;
    assign quantum_left = quantum_left_reg;

`ifndef SYNTHESIS
    a_full_means_all_used: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (code_reg == mlfq_pkg::RES_FULL)) |-> (&used_reg))
        else $error("table full reported while a slot is free");

    a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= mlfq_pkg::STEP_W'(mlfq_pkg::NUM_LEVELS))
        else $error("charge ran more steps than there are levels");

    a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (new_level_reg <= mlfq_pkg::LAST_LEVEL))
        else $error("reported level below the lowest level");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/mlfq_process_table.sv
`default_nettype none

// Process slot table for a multilevel feedback queue. A request is taken when start is high
// and busy is low; its inputs are captured at that edge. Every request walks all slots once,
// one slot per cycle, and a charge then takes 0 to 4 level steps through the shared subtract
// unit, each step registered, before the charge state ends; the request then passes the
// finish state, which writes the slot back, and busy returns low after it.
// The response is shown for exactly one cycle with done high, in the cycle busy returns low,
// and the receiver cannot stall it. A new request may be started in that same cycle.
// Configuration registers sit at byte address 8 times their index on the APB port; the user
// must write them only while busy is low, as the block itself does not enforce it.
module mlfq_process_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    req_type,
    input  wire logic [mlfq_pkg::PID_W-1:0]    target_pid,
    input  wire logic [mlfq_pkg::QUANT_W-1:0]  run_amount,
    input  wire logic [mlfq_pkg::TIME_W-1:0]   time_now,
    input  wire logic                          input_pending,
    output logic                               done,
    output logic [1:0]                         result_code,
    output logic [mlfq_pkg::PID_W-1:0]         given_pid,
    output logic [mlfq_pkg::LEVEL_W-1:0]       new_level,
    output logic [mlfq_pkg::QUANT_W-1:0]       quantum_left,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mlfq_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mlfq_pkg::DATA_W-1:0]   pwdata,
    output logic      [mlfq_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    mlfq_pkg::cfg_t cfg;
    mlfq_pkg::cmd_t cmd;
    mlfq_pkg::sts_t sts;

    mlfq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mlfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    mlfq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .req_type      (req_type),
        .target_pid    (target_pid),
        .run_amount    (run_amount),
        .time_now      (time_now),
        .input_pending (input_pending),
        .sts           (sts),
        .done          (done),
        .result_code   (result_code),
        .given_pid     (given_pid),
        .new_level     (new_level),
        .quantum_left  (quantum_left)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import mlfq_pkg::*;

    typedef struct packed {
        logic [1:0]         kind;
        logic [PID_W-1:0]   pid;
        logic [QUANT_W-1:0] run;
        logic [TIME_W-1:0]  now;
        logic               pending;
    } sched_req_t;

    typedef struct packed {
        logic [1:0]         code;
        logic [PID_W-1:0]   pid;
        logic [LEVEL_W-1:0] level;
        logic [QUANT_W-1:0] quantum;
    } sched_resp_t;

    class mlfq_scoreboard;
        logic [QUANT_W-1:0] quantum_cfg [NUM_QREGS];
        logic [TIME_W-1:0]  period_cfg;
        logic [PID_W-1:0]   shell_cfg;
        logic [PID_W-1:0]   owner [NUM_SLOTS];
        bit                 used [NUM_SLOTS];
        logic [LEVEL_W-1:0] level [NUM_SLOTS];
        logic [QUANT_W-1:0] quantum [NUM_SLOTS];
        logic [PID_W-1:0]   pid_count;
        logic [TIME_W-1:0]  last_reset;
        sched_resp_t        expected [$];
        int                 errors;

        function new();
            quantum_cfg[0] = QUANTUM0_RST;
            quantum_cfg[1] = QUANTUM1_RST;
            quantum_cfg[2] = QUANTUM2_RST;
            quantum_cfg[3] = QUANTUM3_RST;
            quantum_cfg[4] = QUANTUM4_RST;
            period_cfg = PERIOD_RST;
            shell_cfg = SHELL_RST;
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                owner[k] = '0;
                used[k] = 1'b0;
                level[k] = '0;
                quantum[k] = '0;
            end
            pid_count = '0;
            last_reset = '0;
            errors = 0;
        endfunction

        function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
            case (idx)
                REG_PERIOD: period_cfg = value;
                REG_SHELL: shell_cfg = value[PID_W-1:0];
                default: quantum_cfg[idx] = value[QUANT_W-1:0];
            endcase
        endfunction

        function logic [QUANT_W-1:0] quantum_of(input int lvl);
            return quantum_cfg[(lvl > NUM_LEVELS - 1) ? NUM_LEVELS - 1 : lvl];
        endfunction

        function int first_slot(input logic [PID_W-1:0] pid);
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                if (used[k] && owner[k] == pid)
                begin
                    return k;
                end
            end
            return -1;
        endfunction

        function void promote(input int slot);
            level[slot] = '0;
            quantum[slot] = quantum_of(0);
        endfunction

        function void note_request(input sched_req_t r);
            sched_resp_t        resp;
            int                 slot;
            int                 lvl;
            logic [QUANT_W-1:0] rem;
            logic [QUANT_W-1:0] q;
            bit                 found;
            resp = '0;
            case (r.kind)
                REQ_ALLOC:
                begin
                    slot = -1;
                    for (int k = 0; k < NUM_SLOTS; k++)
                    begin
                        if (!used[k])
                        begin
                            slot = k;
                            break;
                        end
                    end
                    if (slot < 0)
                    begin
                        resp.code = RES_FULL;
                    end
                    else
                    begin
                        pid_count = pid_count + 1'b1;
                        owner[slot] = pid_count;
                        used[slot] = 1'b1;
                        promote(slot);
                        resp.pid = pid_count;
                    end
                end
                REQ_FREE:
                begin
                    found = 1'b0;
                    for (int k = 0; k < NUM_SLOTS; k++)
                    begin
                        if (used[k] && owner[k] == r.pid)
                        begin
                            used[k] = 1'b0;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        resp.code = RES_NOT_FOUND;
                    end
                end
                REQ_CHARGE:
                begin
                    slot = first_slot(r.pid);
                    if (slot < 0)
                    begin
                        resp.code = RES_NOT_FOUND;
                    end
                    else
                    begin
                        rem = r.run;
                        lvl = level[slot];
                        if (lvl > NUM_LEVELS - 1)
                        begin
                            lvl = NUM_LEVELS - 1;
                        end
                        q = quantum[slot];
                        for (int k = 0; k < NUM_LEVELS && rem != 0; k++)
                        begin
                            if (rem >= q)
                            begin
                                rem = rem - q;
                                if (lvl < NUM_LEVELS - 1)
                                begin
                                    lvl++;
                                end
                                q = quantum_of(lvl);
                            end
                            else
                            begin
                                q = q - rem;
                                rem = '0;
                            end
                            if (lvl == NUM_LEVELS - 1)
                            begin
                                break;
                            end
                        end
                        level[slot] = LEVEL_W'(lvl);
                        quantum[slot] = q;
                        resp.level = LEVEL_W'(lvl);
                        resp.quantum = q;
                    end
                end
                default:
                begin
                    if (r.pending)
                    begin
                        slot = first_slot(shell_cfg);
                        if (slot >= 0)
                        begin
                            promote(slot);
                        end
                    end
                    if (r.now - last_reset >= period_cfg)
                    begin
                        for (int k = 0; k < NUM_SLOTS; k++)
                        begin
                            if (used[k])
                            begin
                                promote(k);
                            end
                        end
                        last_reset = r.now;
                    end
                end
            endcase
            expected.push_back(resp);
        endfunction

        function void check_result(input sched_resp_t got);
            sched_resp_t want;
            if (expected.size() == 0)
            begin
                $display("%0t: response with no request outstanding: code %0d pid %0d level %0d quantum %0d",
                         $time, got.code, got.pid, got.level, got.quantum);
                errors++;
                return;
            end
            want = expected.pop_front();
            if (got.code !== want.code)
            begin
                $display("%0t: result_code expected %0d, got %0d", $time, want.code, got.code);
                errors++;
            end
            if (got.pid !== want.pid)
            begin
                $display("%0t: given_pid expected %0d, got %0d", $time, want.pid, got.pid);
                errors++;
            end
            if (got.level !== want.level)
            begin
                $display("%0t: new_level expected %0d, got %0d", $time, want.level, got.level);
                errors++;
            end
            if (got.quantum !== want.quantum)
            begin
                $display("%0t: quantum_left expected %0d, got %0d", $time, want.quantum, got.quantum);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           req_type = '0;
    logic [PID_W-1:0]     target_pid = '0;
    logic [QUANT_W-1:0]   run_amount = '0;
    logic [TIME_W-1:0]    time_now = '0;
    logic                 input_pending = 1'b0;
    logic                 done;
    logic [1:0]           result_code;
    logic [PID_W-1:0]     given_pid;
    logic [LEVEL_W-1:0]   new_level;
    logic [QUANT_W-1:0]   quantum_left;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    mlfq_scoreboard sb;
    int             quiet_left = 0;

    mlfq_process_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .target_pid    (target_pid),
        .run_amount    (run_amount),
        .time_now      (time_now),
        .input_pending (input_pending),
        .done          (done),
        .result_code   (result_code),
        .given_pid     (given_pid),
        .new_level     (new_level),
        .quantum_left  (quantum_left),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result({result_code, given_pid, new_level, quantum_left});
        end
    end

    function automatic sched_req_t mk(input logic [1:0] kind, input logic [PID_W-1:0] pid,
                                      input logic [QUANT_W-1:0] run,
                                      input logic [TIME_W-1:0] now, input logic pending);
        sched_req_t r;
        r.kind = kind;
        r.pid = pid;
        r.run = run;
        r.now = now;
        r.pending = pending;
        return r;
    endfunction

    function automatic int pick_live_slot();
        int live [$];
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (sb.used[k])
            begin
                live.push_back(k);
            end
        end
        if (live.size() == 0)
        begin
            return -1;
        end
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic logic [PID_W-1:0] some_pid();
        int slot;
        slot = pick_live_slot();
        if (slot >= 0 && $urandom_range(0, 6) != 0)
        begin
            return sb.owner[slot];
        end
        return PID_W'($urandom);
    endfunction

    function automatic bit table_full();
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (!sb.used[k])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic sched_req_t random_request();
        sched_req_t         r;
        int                 roll;
        int                 slot;
        logic [QUANT_W-1:0] base;
        r = mk(REQ_ALLOC, PID_W'($urandom), $urandom, {$urandom, $urandom}, 1'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 45 && table_full() && $urandom_range(0, 3) != 0)
        begin
            roll = 50;
        end
        if (roll < 45)
        begin
            r.kind = REQ_ALLOC;
        end
        else if (roll < 75)
        begin
            r.kind = REQ_FREE;
            r.pid = some_pid();
        end
        else if (roll < 92)
        begin
            r.kind = REQ_CHARGE;
            r.pid = some_pid();
            slot = sb.first_slot(r.pid);
            base = sb.quantum_cfg[$urandom_range(0, NUM_QREGS - 1)];
            case ($urandom_range(0, 9))
                0: r.run = '0;
                1: r.run = '1;
                2: r.run = $urandom;
                3: r.run = (slot >= 0) ? sb.quantum[slot] : base;
                default: r.run = $urandom_range(0, (base > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF
                                                                           : 2 * base + 1);
            endcase
        end
        else
        begin
            r.kind = REQ_CHECK;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: r.now = sb.last_reset + $urandom_range(0, 20);
                4, 5: r.now = sb.last_reset + sb.period_cfg;
                6: r.now = sb.last_reset + sb.period_cfg - 1'b1;
                default: r.now = {$urandom, $urandom};
            endcase
        end
        return r;
    endfunction

    task automatic send(input sched_req_t r);
        int gap;
        if (quiet_left > 0)
        begin
            gap = 0;
            quiet_left--;
        end
        else
        begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 19) == 0)
            begin
                quiet_left = $urandom_range(10, 30);
            end
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= r.kind;
        target_pid <= r.pid;
        run_amount <= r.run;
        time_now <= r.now;
        input_pending <= r.pending;
        do @(posedge clk); while (busy);
        sb.note_request(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_setting(input int n);
        for (int l = 0; l < NUM_QREGS; l++)
        begin
            case (n)
                0: write_reg(REG_IDX_W'(REG_QUANTUM0 + l), 64'd1);
                1: write_reg(REG_IDX_W'(REG_QUANTUM0 + l), 64'hFFFF_FFFF);
                2: write_reg(REG_IDX_W'(REG_QUANTUM0 + l), (l % 2 == 0) ? 64'd0 : 64'(l * 3));
                3: write_reg(REG_IDX_W'(REG_QUANTUM0 + l), 64'($urandom_range(1, 1000)));
                4: write_reg(REG_IDX_W'(REG_QUANTUM0 + l),
                             64'(QUANTUM0_RST + QUANTUM0_RST * l));
                default: write_reg(REG_IDX_W'(REG_QUANTUM0 + l), 64'($urandom));
            endcase
        end
        case (n)
            0:
            begin
                write_reg(REG_PERIOD, 64'd1);
                write_reg(REG_SHELL, 64'(some_pid()));
            end
            1:
            begin
                write_reg(REG_PERIOD, '1);
                write_reg(REG_SHELL, 64'd0);
            end
            2:
            begin
                write_reg(REG_PERIOD, 64'd0);
                write_reg(REG_SHELL, 64'd255);
            end
            3:
            begin
                write_reg(REG_PERIOD, 64'($urandom_range(1, 50)));
                write_reg(REG_SHELL, 64'(some_pid()));
            end
            4:
            begin
                write_reg(REG_PERIOD, 64'(PERIOD_RST));
                write_reg(REG_SHELL, 64'(SHELL_RST));
            end
            default:
            begin
                write_reg(REG_PERIOD, {$urandom, $urandom});
                write_reg(REG_SHELL, 64'(some_pid()));
            end
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk(REQ_CHECK, '0, '0, '0, 1'b1));
        repeat (NUM_SLOTS) send(mk(REQ_ALLOC, '0, '0, '0, 1'b0));
        send(mk(REQ_ALLOC, '1, '1, '1, 1'b1));
        send(mk(REQ_CHARGE, 8'd3, '0, '0, 1'b0));
        send(mk(REQ_CHARGE, 8'd3, '1, '0, 1'b0));
        send(mk(REQ_CHARGE, 8'd2, 32'd250000, '0, 1'b0));
        send(mk(REQ_CHARGE, 8'd200, 32'd5, '0, 1'b0));
        send(mk(REQ_FREE, 8'd200, '0, '0, 1'b0));
        send(mk(REQ_CHECK, '0, '0, 64'd5, 1'b1));
        send(mk(REQ_CHARGE, 8'd2, 32'd1, '0, 1'b0));
        send(mk(REQ_CHECK, '0, '0, '1, 1'b0));
        send(mk(REQ_CHARGE, 8'd3, 32'd1, '0, 1'b0));
        send(mk(REQ_FREE, 8'd5, '0, '0, 1'b0));
        send(mk(REQ_ALLOC, '0, '0, '0, 1'b0));

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            apply_setting(ph);
            for (int n = 0; n < 120; n++)
            begin
                send(random_request());
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.expected.size() == 0)
        begin
            $display("mlfq_process_table test passed");
        end
        else
        begin
            $display("mlfq_process_table test failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("mlfq_process_table test failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mlfq_pkg.sv
hw/rtl/mlfq_regs.sv
hw/rtl/mlfq_ctrl.sv
hw/rtl/mlfq_dp.sv
hw/rtl/mlfq_process_table.sv
tb/tb.sv
